[design/vso_pkg.sv]
// Shared types, constants and lookup functions for the vec3 sine oscillator.
`default_nettype none
package vso_pkg;

	localparam int NUM_W     = 57;  // |t| * 1024 magnitude
	localparam int DEN_W     = 21;  // |period| magnitude
	localparam int MOD_W     = 19;  // residue mod TWO_PI
	localparam int ARG_W     = 28;  // biased argument before reduction
	localparam int AX_W      = 17;  // folded angle, Q16
	localparam int X2_W      = 32;
	localparam int H_W       = 31;
	localparam int M_W       = 52;  // |amp| * |scale|
	localparam int PROD_W    = 43;
	localparam int RES_W     = 45;

	localparam int DIV_CELLS = NUM_W;
	localparam int RED_CELLS = 10;
	localparam int SIN_CELLS = 5;

	localparam logic [MOD_W-1:0] TWO_PI  = 19'd411775;
	localparam logic [MOD_W-1:0] PI_Q    = 19'd205887;
	localparam logic [MOD_W-1:0] HALF_PI = 19'd102944;
	localparam logic [ARG_W-1:0] PH_BIAS = 28'(163 * 411775);
	localparam logic [H_W-1:0]   ONE_Q30 = 31'h4000_0000;

	// exact floor(v / d) for v < 2^32 as (v * M) >> (32 + ceil(log2 d))
	localparam logic [32:0] SIN_M0 = 33'(((64'd1 << 39) + 64'd109) / 64'd110);
	localparam logic [32:0] SIN_M1 = 33'(((64'd1 << 39) + 64'd71) / 64'd72);
	localparam logic [32:0] SIN_M2 = 33'(((64'd1 << 38) + 64'd41) / 64'd42);
	localparam logic [32:0] SIN_M3 = 33'(((64'd1 << 37) + 64'd19) / 64'd20);
	localparam logic [32:0] SIN_M4 = 33'(((64'd1 << 35) + 64'd5) / 64'd6);

	localparam logic [1:0] COMP_NONE = 2'd3;

	typedef enum logic [2:0] {
		REG_SPEED,
		REG_OVERRIDE,
		REG_AMP_SCALE,
		REG_AMP,
		REG_PERIOD,
		REG_PHASE,
		REG_OFFSET
	} cfg_reg_t;

	typedef struct packed {
		logic       v;
		logic [1:0] comp;
		logic       inv;
		logic       pz;
		logic       neg;
	} side_t;

	function automatic logic signed [20:0] lane21(input logic [62:0] vec, input logic [1:0] c);
		logic signed [20:0] r;
		case (c)
			2'd0: r = vec[20:0];
			2'd1: r = vec[41:21];
			2'd2: r = vec[62:42];
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic logic [32:0] sin_mul(input logic [2:0] idx);
		logic [32:0] r;
		case (idx)
			3'd0: r = SIN_M0;
			3'd1: r = SIN_M1;
			3'd2: r = SIN_M2;
			3'd3: r = SIN_M3;
			default: r = SIN_M4;
		endcase
		return r;
	endfunction

	function automatic logic [5:0] sin_shift(input logic [2:0] idx);
		logic [5:0] r;
		case (idx)
			3'd0: r = 6'd39;
			3'd1: r = 6'd39;
			3'd2: r = 6'd38;
			3'd3: r = 6'd37;
			default: r = 6'd35;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

[design/vec3_sine_oscillator_top.sv]
// Top level of the vec3 sine oscillator: config registers, cell chains, output skid.
// Throughput: one request per cycle while the skid entry is empty; the 57-cell divider
// chain, 10 reduction cells and 5 two-stage sine cells all advance together.
// A stalled output holds one result plus one in the skid entry; input stalls then.
// Reset clears all valid bits and loads the register defaults.
`default_nettype none
module vec3_sine_oscillator_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // time_req
	input  logic [1:0]  s_axis_tuser,   // component
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // value
	output logic [1:0]  m_axis_tuser,   // period_zero, saturated
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [62:0] cfg_data
);

	typedef struct packed {
		logic [31:0] value;
		logic        sat;
		logic        pz;
	} out_t;

	logic [31:0] speed_q, ovr_q, scale_q;
	logic [62:0] amp_q, period_q, phase_q, offset_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_q  <= 32'd65536;
			ovr_q    <= '0;
			scale_q  <= 32'd65536;
			amp_q    <= 63'h0000_0000_8000_0400;
			period_q <= 63'h0010_0000_8000_0400;
			phase_q  <= 63'd1608;
			offset_q <= '0;
		end else if (cfg_we) begin
			case (vso_pkg::cfg_reg_t'(cfg_index))
				vso_pkg::REG_SPEED:     speed_q  <= cfg_data[31:0];
				vso_pkg::REG_OVERRIDE:  ovr_q    <= cfg_data[31:0];
				vso_pkg::REG_AMP_SCALE: scale_q  <= cfg_data[31:0];
				vso_pkg::REG_AMP:       amp_q    <= cfg_data;
				vso_pkg::REG_PERIOD:    period_q <= cfg_data;
				vso_pkg::REG_PHASE:     phase_q  <= cfg_data;
				vso_pkg::REG_OFFSET:    offset_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// output buffer with skid entry
	logic main_v_q, skid_v_q;
	out_t main_q, skid_q;
	logic ce;
	logic accept;
	logic r_v;
	out_t r_d;

	assign ce            = !skid_v_q;
	assign s_axis_tready = ce;
	assign accept        = s_axis_tvalid && ce;
	assign m_axis_tvalid = main_v_q;
	assign m_axis_tdata  = main_q.value;
	assign m_axis_tuser  = {main_q.sat, main_q.pz};

	// stage 1: time * speed
	vso_pkg::side_t     side_s1;
	logic signed [63:0] prod_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s1 <= '0;
		end else if (ce) begin
			side_s1 <= '{v: accept, comp: s_axis_tuser,
				inv: s_axis_tuser == vso_pkg::COMP_NONE, pz: 1'b0, neg: 1'b0};
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			prod_s1 <= $signed(s_axis_tdata) * $signed(speed_q);
		end
	end

	// stage 2: effective time, divider operands
	logic signed [47:0] t_c;
	logic        [47:0] tmag_c;
	logic signed [20:0] per_c;
	vso_pkg::side_t                side_s2;
	logic [vso_pkg::NUM_W-1:0]     num_s2;
	logic [vso_pkg::DEN_W-1:0]     den_s2;

	always_comb begin
		t_c    = (ovr_q != '0) ? 48'($signed(ovr_q)) : prod_s1[63:16];
		tmag_c = t_c[47] ? 48'(-t_c) : 48'(t_c);
		per_c  = vso_pkg::lane21(period_q, side_s1.comp);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s2 <= '0;
		end else if (ce) begin
			side_s2 <= '{v: side_s1.v, comp: side_s1.comp, inv: side_s1.inv,
				pz: per_c == '0, neg: t_c[47] ^ per_c[20]};
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			num_s2 <= {tmag_c[46:0], 10'd0};
			den_s2 <= per_c[20] ? vso_pkg::DEN_W'(-per_c) : vso_pkg::DEN_W'(per_c);
		end
	end

	// divider chain
	vso_pkg::side_t            div_side [0:vso_pkg::DIV_CELLS];
	logic [vso_pkg::NUM_W-1:0] div_num  [0:vso_pkg::DIV_CELLS];
	logic [vso_pkg::DEN_W-1:0] div_rem  [0:vso_pkg::DIV_CELLS];
	logic [vso_pkg::DEN_W-1:0] div_den  [0:vso_pkg::DIV_CELLS];
	logic [vso_pkg::MOD_W-1:0] div_mr   [0:vso_pkg::DIV_CELLS];

	assign div_side[0] = side_s2;
	assign div_num[0]  = num_s2;
	assign div_rem[0]  = '0;
	assign div_den[0]  = den_s2;
	assign div_mr[0]   = '0;

	for (genvar i = 0; i < vso_pkg::DIV_CELLS; i++) begin : g_div
		vso_div_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ce     (ce),
			.side_i (div_side[i]),
			.num_i  (div_num[i]),
			.rem_i  (div_rem[i]),
			.den_i  (div_den[i]),
			.mr_i   (div_mr[i]),
			.side_o (div_side[i+1]),
			.num_o  (div_num[i+1]),
			.rem_o  (div_rem[i+1]),
			.den_o  (div_den[i+1]),
			.mr_o   (div_mr[i+1])
		);
	end

	// quotient residue plus phase, biased positive
	vso_pkg::side_t            qend_side;
	logic [vso_pkg::MOD_W-1:0] qend_mr;
	logic [vso_pkg::MOD_W-1:0] qmod_c;
	logic signed [20:0]        ph_c;
	logic [vso_pkg::ARG_W-1:0] ph64_c;
	vso_pkg::side_t            side_sa;
	logic [vso_pkg::ARG_W-1:0] a_sa;

	assign qend_side = div_side[vso_pkg::DIV_CELLS];
	assign qend_mr   = div_mr[vso_pkg::DIV_CELLS];

	always_comb begin
		qmod_c = (qend_side.neg && qend_mr != '0) ? vso_pkg::TWO_PI - qend_mr : qend_mr;
		ph_c   = vso_pkg::lane21(phase_q, qend_side.comp);
		ph64_c = {ph_c[20], ph_c, 6'd0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_sa <= '0;
		end else if (ce) begin
			side_sa <= qend_side;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			a_sa <= vso_pkg::ARG_W'(qmod_c) + ph64_c + vso_pkg::PH_BIAS;
		end
	end

	// reduction chain
	vso_pkg::side_t            red_side [0:vso_pkg::RED_CELLS];
	logic [vso_pkg::ARG_W-1:0] red_a    [0:vso_pkg::RED_CELLS];

	assign red_side[0] = side_sa;
	assign red_a[0]    = a_sa;

	for (genvar i = 0; i < vso_pkg::RED_CELLS; i++) begin : g_red
		vso_red_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ce     (ce),
			.kk     (4'(vso_pkg::RED_CELLS - 1 - i)),
			.side_i (red_side[i]),
			.a_i    (red_a[i]),
			.side_o (red_side[i+1]),
			.a_o    (red_a[i+1])
		);
	end

	// fold into [0, pi/2] with sign
	logic [vso_pkg::MOD_W-1:0] arg_c, mag_c, fold_c;
	logic                      fneg_c;
	vso_pkg::side_t            fside_c;
	vso_pkg::side_t            side_sf;
	logic [vso_pkg::AX_W-1:0]  ax_sf;

	always_comb begin
		arg_c  = red_a[vso_pkg::RED_CELLS][vso_pkg::MOD_W-1:0];
		fneg_c = arg_c > vso_pkg::PI_Q;
		mag_c  = fneg_c ? vso_pkg::TWO_PI - arg_c : arg_c;
		fold_c = (mag_c > vso_pkg::HALF_PI) ? vso_pkg::PI_Q - mag_c : mag_c;
		fside_c     = red_side[vso_pkg::RED_CELLS];
		fside_c.neg = fneg_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_sf <= '0;
		end else if (ce) begin
			side_sf <= fside_c;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			ax_sf <= vso_pkg::AX_W'(fold_c);
		end
	end

	// x squared
	logic [30:0]               x_sf;
	logic [61:0]               xx_c;
	vso_pkg::side_t            side_sx;
	logic [vso_pkg::AX_W-1:0]  ax_sx;
	logic [vso_pkg::X2_W-1:0]  x2_sx;

	assign x_sf = {ax_sf, 14'd0};
	assign xx_c = 62'(x_sf) * 62'(x_sf);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_sx <= '0;
		end else if (ce) begin
			side_sx <= side_sf;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			ax_sx <= ax_sf;
			x2_sx <= xx_c[61:30];
		end
	end

	// sine polynomial chain
	vso_pkg::side_t           sin_side [0:vso_pkg::SIN_CELLS];
	logic [vso_pkg::AX_W-1:0] sin_ax   [0:vso_pkg::SIN_CELLS];
	logic [vso_pkg::X2_W-1:0] sin_x2   [0:vso_pkg::SIN_CELLS];
	logic [vso_pkg::H_W-1:0]  sin_h    [0:vso_pkg::SIN_CELLS];

	assign sin_side[0] = side_sx;
	assign sin_ax[0]   = ax_sx;
	assign sin_x2[0]   = x2_sx;
	assign sin_h[0]    = vso_pkg::ONE_Q30;

	for (genvar i = 0; i < vso_pkg::SIN_CELLS; i++) begin : g_sin
		vso_sine_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ce     (ce),
			.idx    (3'(i)),
			.side_i (sin_side[i]),
			.ax_i   (sin_ax[i]),
			.x2_i   (sin_x2[i]),
			.h_i    (sin_h[i]),
			.side_o (sin_side[i+1]),
			.ax_o   (sin_ax[i+1]),
			.x2_o   (sin_x2[i+1]),
			.h_o    (sin_h[i+1])
		);
	end

	// s = x * h, amplitude magnitude product
	vso_pkg::side_t     send_side;
	logic [30:0]        xs_c;
	logic [61:0]        xh_c;
	logic signed [20:0] amp_c;
	logic [20:0]        amag_c;
	logic [31:0]        smag_c;
	logic [52:0]        m_c;
	vso_pkg::side_t     sside_c;
	vso_pkg::side_t     side_ss;
	logic [30:0]        s_ss;
	logic [vso_pkg::M_W-1:0] m_ss;

	assign send_side = sin_side[vso_pkg::SIN_CELLS];

	always_comb begin
		xs_c   = {sin_ax[vso_pkg::SIN_CELLS], 14'd0};
		xh_c   = 62'(xs_c) * 62'(sin_h[vso_pkg::SIN_CELLS]);
		amp_c  = vso_pkg::lane21(amp_q, send_side.comp);
		amag_c = amp_c[20] ? 21'(-amp_c) : 21'(amp_c);
		smag_c = scale_q[31] ? 32'(-$signed(scale_q)) : scale_q;
		m_c    = 53'(amag_c) * 53'(smag_c);
		sside_c     = send_side;
		sside_c.neg = send_side.neg ^ amp_c[20] ^ scale_q[31];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_ss <= '0;
		end else if (ce) begin
			side_ss <= sside_c;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			s_ss <= xh_c[60:30];
			m_ss <= m_c[vso_pkg::M_W-1:0];
		end
	end

	// partial products
	vso_pkg::side_t side_sp;
	logic [50:0]    hi_sp;
	logic [62:0]    lo_sp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_sp <= '0;
		end else if (ce) begin
			side_sp <= side_ss;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			hi_sp <= 51'(s_ss) * 51'(m_ss[51:32]);
			lo_sp <= 63'(s_ss) * 63'(m_ss[31:0]);
		end
	end

	// combine and scale
	logic [82:0]                sum_c;
	vso_pkg::side_t             side_sq;
	logic [vso_pkg::PROD_W-1:0] prod_sq;

	assign sum_c = {hi_sp, 32'd0} + 83'(lo_sp);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_sq <= '0;
		end else if (ce) begin
			side_sq <= side_sp;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			prod_sq <= sum_c[82:40];
		end
	end

	// offset, saturation, special cases
	logic signed [20:0]               off_c;
	logic signed [vso_pkg::RES_W-1:0] off64_c, res_c;
	logic                             hi_sat_c, lo_sat_c;

	always_comb begin
		off_c    = vso_pkg::lane21(offset_q, side_sq.comp);
		off64_c  = vso_pkg::RES_W'($signed({off_c, 6'd0}));
		res_c    = side_sq.neg ? off64_c - $signed({2'b00, prod_sq})
			: off64_c + $signed({2'b00, prod_sq});
		hi_sat_c = res_c > $signed(45'sd2147483647);
		lo_sat_c = res_c < -$signed(45'sd2147483648);
		r_v      = side_sq.v;
		r_d      = '0;
		if (side_sq.inv) begin
			r_d = '0;
		end else if (side_sq.pz) begin
			r_d.value = off64_c[31:0];
			r_d.pz    = 1'b1;
		end else if (hi_sat_c) begin
			r_d.value = 32'h7fff_ffff;
			r_d.sat   = 1'b1;
		end else if (lo_sat_c) begin
			r_d.value = 32'h8000_0000;
			r_d.sat   = 1'b1;
		end else begin
			r_d.value = res_c[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!main_v_q || m_axis_tready) begin
			if (skid_v_q) begin
				skid_v_q <= 1'b0;
			end else begin
				main_v_q <= r_v;
			end
		end else if (ce && r_v) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!main_v_q || m_axis_tready) begin
			main_q <= skid_v_q ? skid_q : r_d;
		end else if (ce && r_v) begin
			skid_q <= r_d;
		end
	end

endmodule
`default_nettype wire

[design/vso_div_cell.sv]
// One restoring-division cell: one quotient bit, folded into a running residue mod 2*pi.
`default_nettype none
module vso_div_cell (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        ce,
	input  vso_pkg::side_t              side_i,
	input  logic [vso_pkg::NUM_W-1:0]   num_i,
	input  logic [vso_pkg::DEN_W-1:0]   rem_i,
	input  logic [vso_pkg::DEN_W-1:0]   den_i,
	input  logic [vso_pkg::MOD_W-1:0]   mr_i,
	output vso_pkg::side_t              side_o,
	output logic [vso_pkg::NUM_W-1:0]   num_o,
	output logic [vso_pkg::DEN_W-1:0]   rem_o,
	output logic [vso_pkg::DEN_W-1:0]   den_o,
	output logic [vso_pkg::MOD_W-1:0]   mr_o
);

	logic [vso_pkg::DEN_W:0]   r2;
	logic                      ge;
	logic [vso_pkg::DEN_W-1:0] rem_n;
	logic [vso_pkg::MOD_W:0]   m2;
	logic [vso_pkg::MOD_W-1:0] mr_n;

	always_comb begin
		r2    = {rem_i, num_i[vso_pkg::NUM_W-1]};
		ge    = r2 >= {1'b0, den_i};
		rem_n = ge ? vso_pkg::DEN_W'(r2 - {1'b0, den_i}) : vso_pkg::DEN_W'(r2);
		m2    = {mr_i, ge};
		mr_n  = (m2 >= {1'b0, vso_pkg::TWO_PI}) ?
			vso_pkg::MOD_W'(m2 - {1'b0, vso_pkg::TWO_PI}) : vso_pkg::MOD_W'(m2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_o <= '0;
		end else if (ce) begin
			side_o <= side_i;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			num_o <= {num_i[vso_pkg::NUM_W-2:0], 1'b0};
			rem_o <= rem_n;
			den_o <= den_i;
			mr_o  <= mr_n;
		end
	end

endmodule
`default_nettype wire

[design/vso_red_cell.sv]
// One modular reduction cell: subtracts 2*pi << kk when the argument reaches it.
`default_nettype none
module vso_red_cell (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      ce,
	input  logic [3:0]                kk,
	input  vso_pkg::side_t            side_i,
	input  logic [vso_pkg::ARG_W-1:0] a_i,
	output vso_pkg::side_t            side_o,
	output logic [vso_pkg::ARG_W-1:0] a_o
);

	logic [vso_pkg::ARG_W-1:0] sub;

	assign sub = vso_pkg::ARG_W'(vso_pkg::TWO_PI) << kk;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_o <= '0;
		end else if (ce) begin
			side_o <= side_i;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			a_o <= (a_i >= sub) ? a_i - sub : a_i;
		end
	end

endmodule
`default_nettype wire

[design/vso_sine_cell.sv]
// One Horner step of the sine polynomial: h = 1 - (x2 * h) / d, two stages.
`default_nettype none
module vso_sine_cell (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      ce,
	input  logic [2:0]                idx,
	input  vso_pkg::side_t            side_i,
	input  logic [vso_pkg::AX_W-1:0]  ax_i,
	input  logic [vso_pkg::X2_W-1:0]  x2_i,
	input  logic [vso_pkg::H_W-1:0]   h_i,
	output vso_pkg::side_t            side_o,
	output logic [vso_pkg::AX_W-1:0]  ax_o,
	output logic [vso_pkg::X2_W-1:0]  x2_o,
	output logic [vso_pkg::H_W-1:0]   h_o
);

	vso_pkg::side_t             side_s1;
	logic [vso_pkg::AX_W-1:0]   ax_s1;
	logic [vso_pkg::X2_W-1:0]   x2_s1;
	logic [vso_pkg::X2_W-1:0]   v_s1;
	logic [62:0]                p;
	logic [64:0]                qp;
	logic [31:0]                q;

	assign p  = 63'(x2_i) * 63'(h_i);
	assign qp = 65'(v_s1) * 65'(vso_pkg::sin_mul(idx));
	assign q  = 32'(qp >> vso_pkg::sin_shift(idx));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s1 <= '0;
			side_o  <= '0;
		end else if (ce) begin
			side_s1 <= side_i;
			side_o  <= side_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			ax_s1 <= ax_i;
			x2_s1 <= x2_i;
			v_s1  <= p[61:30];
			ax_o  <= ax_s1;
			x2_o  <= x2_s1;
			h_o   <= vso_pkg::ONE_Q30 - vso_pkg::H_W'(q);
		end
	end

endmodule
`default_nettype wire

[tb/vec3_sine_oscillator_top_test.sv]
// Self-checking stream testbench for the vec3 sine oscillator top level.
`timescale 1ns / 1ps
module vec3_sine_oscillator_top_test;

	localparam int CYCLE_LIMIT = 700000;
	localparam logic [2:0] REG_UNUSED = 3'd7;
	localparam logic [1:0] COMP_X = 2'd0;
	localparam logic [1:0] COMP_Z = 2'd2;
	localparam longint TWO_PI_Q = 411775;
	localparam longint PI_Q16 = 205887;
	localparam longint HALF_PI_Q = 102944;
	localparam bit [63:0] UNIT_Q30 = 64'd1073741824;

	typedef struct packed {
		logic [31:0] value;
		logic        period_zero;
		logic        saturated;
	} osc_res_t;

	typedef struct packed {
		logic [31:0] tm;
		logic [1:0]  comp;
	} osc_req_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata = '0;   // time_req
	logic [1:0]  s_axis_tuser = '0;   // component
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;        // value
	logic [1:0]  m_axis_tuser;        // period_zero, saturated
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [62:0] cfg_data = '0;

	vec3_sine_oscillator_top uut (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// register mirror
	bit [31:0] speed_q = 32'd65536;
	bit [31:0] ovr_q = '0;
	bit [31:0] ascale_q = 32'd65536;
	bit [62:0] amp_q = 63'd2147484672;
	bit [62:0] per_q = 63'd4503601774855168;
	bit [62:0] ph_q = 63'd1608;
	bit [62:0] off_q = '0;

	osc_req_t pending[$];
	osc_res_t expected_vals[$];
	int errors = 0;
	int cycles = 0;
	int issued_cnt = 0, acc_cnt = 0, res_cnt = 0, res_seen = 0;
	int tx_gap = 0, rx_gap = 0;
	bit no_idle = 0;
	osc_req_t cur_req;

	function automatic longint lane_q10(bit [62:0] v, bit [1:0] c);
		bit [20:0] f;
		f = 21'(v >> (21 * c));
		return longint'(signed'(f));
	endfunction

	function automatic bit [63:0] sine_mag(bit [63:0] ax);
		bit [63:0] x, x2, h, d;
		x = ax << 14;
		x2 = (x * x) >> 30;
		h = UNIT_Q30;
		for (int i = 0; i < 5; i++) begin
			case (i)
				0: d = 110;
				1: d = 72;
				2: d = 42;
				3: d = 20;
				default: d = 6;
			endcase
			h = UNIT_Q30 - ((x2 * h) >> 30) / d;
		end
		return (x * h) >> 30;
	endfunction

	function automatic osc_res_t osc_eval(bit [31:0] tm, bit [1:0] comp);
		osc_res_t r;
		longint per, off, t, arg, amp, scl, res;
		bit [63:0] ax, s, m, hi, lo, prod;
		bit neg;
		r = '0;
		if (comp == vso_pkg::COMP_NONE) return r;
		per = lane_q10(per_q, comp);
		off = lane_q10(off_q, comp) * 64;
		if (per == 0) begin
			r.value = off[31:0];
			r.period_zero = 1'b1;
			return r;
		end
		if (ovr_q != 0)
			t = longint'(signed'(ovr_q));
		else
			t = (longint'(signed'(tm)) * longint'(signed'(speed_q))) >>> 16;
		arg = (t * 1024) / per + lane_q10(ph_q, comp) * 64;
		arg = arg % TWO_PI_Q;
		if (arg < 0) arg += TWO_PI_Q;
		if (arg > PI_Q16) arg -= TWO_PI_Q;
		neg = arg < 0;
		ax = neg ? -arg : arg;
		if (ax > HALF_PI_Q) ax = PI_Q16 - ax;
		s = sine_mag(ax);
		amp = lane_q10(amp_q, comp);
		scl = longint'(signed'(ascale_q));
		if (amp < 0) neg = !neg;
		if (scl < 0) neg = !neg;
		m = (amp < 0 ? -amp : amp) * (scl < 0 ? -scl : scl);
		hi = s * (m >> 32);
		lo = s * (m & 64'hFFFF_FFFF);
		prod = (hi >> 8) + ((((hi & 64'hFF) << 32) + lo) >> 40);
		res = neg ? off - longint'(prod) : off + longint'(prod);
		if (res > 64'sd2147483647) begin
			res = 64'sd2147483647;
			r.saturated = 1'b1;
		end
		if (res < -64'sd2147483648) begin
			res = -64'sd2147483648;
			r.saturated = 1'b1;
		end
		r.value = res[31:0];
		return r;
	endfunction

	task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %h, want %h (result %0d)", what, got, want, res_cnt);
		errors++;
	endtask

	function automatic int draw_gap();
		return no_idle ? 0 : $urandom_range(0, 13);
	endfunction

	// request driver
	always @(negedge clk) begin
		if (arst_n && issued_cnt == acc_cnt) begin
			if (tx_gap > 0) begin
				tx_gap--;
				s_axis_tvalid <= 1'b0;
			end else if (pending.size() > 0) begin
				cur_req = pending.pop_front();
				s_axis_tdata <= cur_req.tm;
				s_axis_tuser <= cur_req.comp;
				s_axis_tvalid <= 1'b1;
				issued_cnt++;
				tx_gap = draw_gap();
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// result stall driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (res_seen != res_cnt) begin
				res_seen = res_cnt;
				rx_gap = draw_gap();
			end
			if (rx_gap > 0) begin
				rx_gap--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// monitor and checker
	always @(posedge clk) begin
		osc_res_t e;
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout");
			$display("vec3_sine_oscillator_top regression: fail");
			$finish;
		end
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				expected_vals = {expected_vals, osc_eval(s_axis_tdata, s_axis_tuser)};
				acc_cnt++;
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_vals.size() == 0) begin
					flag_mismatch("unexpected result", m_axis_tdata, '0);
				end else begin
					e = expected_vals.pop_front();
					if (m_axis_tdata !== e.value)
						flag_mismatch("value", m_axis_tdata, e.value);
					if (m_axis_tuser[0] !== e.period_zero)
						flag_mismatch("period_zero", 32'(m_axis_tuser[0]),
							32'(e.period_zero));
					if (m_axis_tuser[1] !== e.saturated)
						flag_mismatch("saturated", 32'(m_axis_tuser[1]),
							32'(e.saturated));
				end
				res_cnt++;
			end
		end
	end

	task automatic write_reg(logic [2:0] idx, bit [62:0] d);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			vso_pkg::REG_SPEED: speed_q = d[31:0];
			vso_pkg::REG_OVERRIDE: ovr_q = d[31:0];
			vso_pkg::REG_AMP_SCALE: ascale_q = d[31:0];
			vso_pkg::REG_AMP: amp_q = d;
			vso_pkg::REG_PERIOD: per_q = d;
			vso_pkg::REG_PHASE: ph_q = d;
			vso_pkg::REG_OFFSET: off_q = d;
			default: ;
		endcase
	endtask

	task automatic wait_idle();
		wait (pending.size() == 0 && issued_cnt == acc_cnt && expected_vals.size() == 0);
		repeat (120) @(posedge clk);
	endtask

	function automatic bit [20:0] rnd_lane(int zero_pct);
		if ($urandom_range(0, 99) < zero_pct) return '0;
		case ($urandom_range(0, 2))
			0: return 21'($urandom);
			1: return 21'($urandom_range(0, 4096)) - 21'd2048;
			default: return $urandom_range(0, 1) ? 21'h0FFFFF : 21'h100000;
		endcase
	endfunction

	function automatic bit [62:0] rnd_pack(int zero_pct);
		return {rnd_lane(zero_pct), rnd_lane(zero_pct), rnd_lane(zero_pct)};
	endfunction

	function automatic bit [31:0] rnd_word();
		case ($urandom_range(0, 3))
			0: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			1: return 32'($urandom_range(0, 1 << 18)) - 32'(1 << 17);
			default: return $urandom;
		endcase
	endfunction

	initial begin
		bit [31:0] dir_t [6];
		dir_t = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000};
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		// reset settings: extremes of time on every component
		foreach (dir_t[i])
			for (int c = 0; c < 4; c++)
				pending = {pending, osc_req_t'{dir_t[i], 2'(c)}};
		wait_idle();

		for (int ph = 1; ph <= 8; ph++) begin
			no_idle = (ph == 5);
			case (ph)
				1: write_reg(vso_pkg::REG_SPEED, 63'h8000_0000);
				2: write_reg(vso_pkg::REG_SPEED, 63'h7FFF_FFFF);
				3: write_reg(vso_pkg::REG_SPEED, 63'h0);
				default: write_reg(vso_pkg::REG_SPEED, 63'(rnd_word()));
			endcase
			case (ph)
				4: write_reg(vso_pkg::REG_OVERRIDE, 63'h8000_0000);
				5: write_reg(vso_pkg::REG_OVERRIDE, 63'h7FFF_FFFF);
				6: write_reg(vso_pkg::REG_OVERRIDE, 63'(rnd_word()));
				default: write_reg(vso_pkg::REG_OVERRIDE, 63'h0);
			endcase
			case (ph)
				2: write_reg(vso_pkg::REG_AMP_SCALE, 63'h7FFF_FFFF);
				3: write_reg(vso_pkg::REG_AMP_SCALE, 63'h8000_0000);
				default: write_reg(vso_pkg::REG_AMP_SCALE, 63'(rnd_word()));
			endcase
			case (ph)
				2: write_reg(vso_pkg::REG_AMP, {21'h0FFFFF, 21'h0FFFFF, 21'h0FFFFF});
				3: write_reg(vso_pkg::REG_AMP, {21'h100000, 21'h100000, 21'h100000});
				default: write_reg(vso_pkg::REG_AMP, rnd_pack(5));
			endcase
			case (ph)
				1: write_reg(vso_pkg::REG_PERIOD, {21'h000001, 21'h100000, 21'h0});
				2: write_reg(vso_pkg::REG_PERIOD, {21'h0FFFFF, 21'h000001, 21'h1FFFFF});
				default: write_reg(vso_pkg::REG_PERIOD, rnd_pack(20));
			endcase
			write_reg(vso_pkg::REG_PHASE,
				ph == 3 ? {21'h100000, 21'h0FFFFF, 21'h0} : rnd_pack(5));
			case (ph)
				2: write_reg(vso_pkg::REG_OFFSET, {21'h0FFFFF, 21'h0FFFFF, 21'h0FFFFF});
				3: write_reg(vso_pkg::REG_OFFSET, {21'h100000, 21'h100000, 21'h100000});
				default: write_reg(vso_pkg::REG_OFFSET, rnd_pack(10));
			endcase
			// unmapped index must not disturb any register
			if (ph == 6)
				write_reg(REG_UNUSED, 63'({$urandom, $urandom}));
			for (int n = 0; n < 230; n++)
				pending = {pending, osc_req_t'{rnd_word(),
					2'($urandom_range(COMP_X, vso_pkg::COMP_NONE))}};
			wait_idle();
		end

		repeat (200) @(posedge clk);
		if (errors == 0)
			$display("vec3_sine_oscillator_top regression: pass");
		else
			$display("vec3_sine_oscillator_top regression: fail");
		$finish;
	end

endmodule

[filelist.f]
design/vso_pkg.sv
design/vso_div_cell.sv
design/vso_red_cell.sv
design/vso_sine_cell.sv
design/vec3_sine_oscillator_top.sv
tb/vec3_sine_oscillator_top_test.sv
